[rtl/core/tmg_pkg.sv]
// ----------------------------------------------------------------------------
// tmg_pkg
// Shared types and constants for the trapezoidal motion generator.
// ----------------------------------------------------------------------------
package tmg_pkg;

   localparam int POS_W = 32;
   localparam int SPD_W = 28;
   localparam int LIM_W = 27;
   localparam int ACC_W = 28;
   localparam int DT_W  = 13;

   typedef enum logic [1:0] {
      MODE_IDLE = 2'd0,
      MODE_MOVE = 2'd1,
      MODE_JOG  = 2'd2
   } mode_type;

   typedef enum logic [2:0] {
      ACT_TICK = 3'd0,
      ACT_MOVE = 3'd1,
      ACT_JOG  = 3'd2,
      ACT_STOP = 3'd3,
      ACT_SYNC = 3'd4
   } action_type;

   typedef enum logic [2:0] {
      CSR_DEFAULT_ACCEL = 3'd0,
      CSR_JOG_ACCEL     = 3'd1,
      CSR_SOFT_MIN      = 3'd2,
      CSR_SOFT_MAX      = 3'd3,
      CSR_TICK_PERIOD   = 3'd4
   } csr_index_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_CMD,
      ST_ERR,
      ST_SQRT,
      ST_DV,
      ST_SPEED,
      ST_DP,
      ST_POS,
      ST_CLAMP,
      ST_OUT
   } state_type;

   // controller to datapath
   typedef struct packed {
      logic load;      // capture input item, apply command
      logic err;       // compute error / arrival check
      logic sqrt_go;   // start root unit
      logic sqrt_step; // one root iteration
      logic dv;        // dv = a*dt
      logic speed;     // slew speed
      logic dp;        // dp = v*dt
      logic pos;       // integrate position
      logic clamp;     // soft limits
   } dp_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic       enabled;
      mode_type   mode;
      logic       arrive;
      logic       sqrt_done;
   } dp_status_type;

endpackage

[rtl/core/trapezoidal_motion_generator.sv]
// ----------------------------------------------------------------------------
// trapezoidal_motion_generator
// One-axis trapezoidal setpoint generator, one result per control tick.
// ----------------------------------------------------------------------------
// Each transfer on req_ is one control tick and yields one transfer on rsp_.
// A tick runs through the command step and then, when idle or with the drive
// disabled, straight to the result; on the tick a move arrives, through the
// error step to the result; while jogging, through the multiply, slew,
// integrate and clamp steps; and while moving, the stopping-speed square root
// iterates one result bit per cycle over a 62-bit radicand between the error
// step and the multiply, slew, integrate and clamp steps, each one register stage.
// A stalled result holds off the next tick until it transfers. Configuration
// writes are taken at any time and should only be issued while idle.
module trapezoidal_motion_generator import tmg_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [2:0]              req_action,
   input  logic signed [POS_W-1:0] req_target_pos,
   input  logic [LIM_W-1:0]        req_peak_vel,
   input  logic [ACC_W-1:0]        req_move_accel,
   input  logic signed [SPD_W-1:0] req_jog_vel,
   input  logic signed [POS_W-1:0] req_actual_pos,
   input  logic                    req_drive_enabled,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic signed [POS_W-1:0] rsp_setpoint,
   output logic signed [SPD_W-1:0] rsp_velocity,
   output logic [1:0]              rsp_mode,
   output logic                    rsp_arrived,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [2:0]              csr_index,
   input  logic [31:0]             csr_data
);

   logic [ACC_W-1:0]        def_acc_ff, jog_acc_ff;
   logic signed [POS_W-1:0] smin_ff, smax_ff;
   logic [DT_W-1:0]         dt_ff;

   assign csr_ready = 1'b1;

   // register file, write only
   always_ff @(posedge clock) begin
      if (reset) begin
         def_acc_ff <= ACC_W'(6553600);
         jog_acc_ff <= ACC_W'(13107200);
         smin_ff    <= {1'b1, {(POS_W-1){1'b0}}};
         smax_ff    <= {1'b0, {(POS_W-1){1'b1}}};
         dt_ff      <= DT_W'(66);
      end else if (csr_valid) begin
         case (csr_index_type'(csr_index))
            CSR_DEFAULT_ACCEL: def_acc_ff <= csr_data[ACC_W-1:0];
            CSR_JOG_ACCEL:     jog_acc_ff <= csr_data[ACC_W-1:0];
            CSR_SOFT_MIN:      smin_ff    <= csr_data;
            CSR_SOFT_MAX:      smax_ff    <= csr_data;
            CSR_TICK_PERIOD:   dt_ff      <= csr_data[DT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   dp_cmd_type    cmd;
   dp_status_type status;

   tmg_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready,
      .status, .cmd
   );

   tmg_datapath #(.FRAC_BITS(FRAC_BITS)) u_dp (
      .clock, .reset, .cmd, .status,
      .req_action, .req_target_pos, .req_peak_vel, .req_move_accel,
      .req_jog_vel, .req_actual_pos, .req_drive_enabled,
      .default_accel(def_acc_ff), .jog_accel(jog_acc_ff),
      .soft_min(smin_ff), .soft_max(smax_ff), .tick_period(dt_ff),
      .rsp_setpoint, .rsp_velocity, .rsp_mode, .rsp_arrived
   );

endmodule

[rtl/core/tmg_ctrl.sv]
// ----------------------------------------------------------------------------
// tmg_ctrl
// Sequencer that steps the datapath through one control tick.
// ----------------------------------------------------------------------------
module tmg_ctrl import tmg_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  logic          rsp_ready,
   input  dp_status_type status,
   output dp_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (req_valid) state_in = ST_CMD;
         ST_CMD: begin
            if (!status.enabled || status.mode == MODE_IDLE) state_in = ST_OUT;
            else if (status.mode == MODE_JOG) state_in = ST_DV;
            else state_in = ST_ERR;
         end
         ST_ERR:   state_in = status.arrive ? ST_OUT : ST_SQRT;
         ST_SQRT:  if (status.sqrt_done) state_in = ST_DV;
         ST_DV:    state_in = ST_SPEED;
         ST_SPEED: state_in = ST_DP;
         ST_DP:    state_in = ST_POS;
         ST_POS:   state_in = ST_CLAMP;
         ST_CLAMP: state_in = ST_OUT;
         ST_OUT:   if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_ERR: begin
            cmd.err     = 1'b1;
            cmd.sqrt_go = 1'b1;
         end
         ST_SQRT:  cmd.sqrt_step = 1'b1;
         ST_DV:    cmd.dv = 1'b1;
         ST_SPEED: cmd.speed = 1'b1;
         ST_DP:    cmd.dp = 1'b1;
         ST_POS:   cmd.pos = 1'b1;
         ST_CLAMP: cmd.clamp = 1'b1;
         ST_OUT:   rsp_valid = 1'b1;
         default: begin
         end
      endcase
   end

   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> state_ff == ST_CMD)
      else $error("accept did not start a tick");
   assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while result pending");
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped");

endmodule

[rtl/core/tmg_datapath.sv]
// ----------------------------------------------------------------------------
// tmg_datapath
// State registers, a multiply step per phase, bit-pair root unit.
// ----------------------------------------------------------------------------
module tmg_datapath import tmg_pkg::*; #(
   parameter int FRAC_BITS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  dp_cmd_type              cmd,
   output dp_status_type           status,
   input  logic [2:0]              req_action,
   input  logic signed [POS_W-1:0] req_target_pos,
   input  logic [LIM_W-1:0]        req_peak_vel,
   input  logic [ACC_W-1:0]        req_move_accel,
   input  logic signed [SPD_W-1:0] req_jog_vel,
   input  logic signed [POS_W-1:0] req_actual_pos,
   input  logic                    req_drive_enabled,
   input  logic [ACC_W-1:0]        default_accel,
   input  logic [ACC_W-1:0]        jog_accel,
   input  logic signed [POS_W-1:0] soft_min,
   input  logic signed [POS_W-1:0] soft_max,
   input  logic [DT_W-1:0]         tick_period,
   output logic signed [POS_W-1:0] rsp_setpoint,
   output logic signed [SPD_W-1:0] rsp_velocity,
   output logic [1:0]              rsp_mode,
   output logic                    rsp_arrived
);

   localparam logic [LIM_W-1:0] HALF = LIM_W'(1) << (FRAC_BITS - 1);
   localparam int EPS_I = ((5 << FRAC_BITS) + 500) / 1000;
   localparam logic [POS_W:0] EPS = (POS_W+1)'(EPS_I);
   localparam int RAD_W = 62;         // 2*a*|err| < 2^62
   localparam int ROOT_W = 31;
   localparam int ITER_W = 5;
   localparam int PRD_W = ACC_W + DT_W;
   localparam logic signed [POS_W+1:0] P_MAX = {3'b000, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W+1:0] P_MIN = {3'b111, {(POS_W-1){1'b0}}};

   logic signed [POS_W-1:0] pos_ff, goal_ff;
   logic signed [SPD_W-1:0] spd_ff, jspd_ff;
   logic [LIM_W-1:0]        lim_ff;
   logic [ACC_W-1:0]        acc_ff;
   mode_type                mode_ff;
   logic                    en_ff, arr_ff;
   logic signed [POS_W:0]   err_ff;
   logic [RAD_W-1:0]        rad_ff;
   logic [ROOT_W:0]         root_ff;
   logic [RAD_W-1:0]        rem_ff;
   logic [ITER_W-1:0]       it_ff;
   logic signed [SPD_W+1:0] want_ff;
   logic [ACC_W-1:0]        dv_ff;
   logic signed [SPD_W-1:0] dp_ff;
   logic signed [POS_W+1:0] np_ff;

   // command decode
   logic [ACC_W-1:0] move_acc;
   assign move_acc = (req_move_accel != '0) ? req_move_accel : default_accel;

   // error and speed magnitudes
   logic [SPD_W-1:0] aspd;
   logic signed [POS_W:0] err_c;
   logic [POS_W:0]        aerr_c;
   assign err_c  = {goal_ff[POS_W-1], goal_ff} - {pos_ff[POS_W-1], pos_ff};
   assign aerr_c = err_c[POS_W] ? -err_c : err_c;
   assign aspd   = spd_ff[SPD_W-1] ? -spd_ff : spd_ff;

   // rounded (x*dt)>>F, magnitude form
   function automatic logic [ACC_W-1:0] rnd(input logic [ACC_W+DT_W-1:0] p);
      logic [ACC_W+DT_W:0] t;
      t = {1'b0, p} + ((ACC_W+DT_W+1)'(1) << (FRAC_BITS - 1));
      return ACC_W'(t >> FRAC_BITS);
   endfunction

   // root iteration: two radicand bits per step
   logic [RAD_W+1:0] trial;
   logic [RAD_W+1:0] rem_nx;
   assign rem_nx = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial  = {root_ff, 2'b01};

   logic [ROOT_W-1:0] vstop;
   assign vstop = root_ff[ROOT_W-1:0];
   logic [LIM_W-1:0] vmag;
   assign vmag = (vstop < ROOT_W'(lim_ff)) ? LIM_W'(vstop) : lim_ff;

   // speed slew
   logic signed [SPD_W+2:0] dlt, dvs, snew;
   logic [ACC_W-1:0] acc_sel;
   assign acc_sel = (mode_ff == MODE_JOG) ? jog_accel : acc_ff;
   assign dvs  = $signed({3'b000, dv_ff});
   assign dlt  = $signed({want_ff[SPD_W+1], want_ff}) - $signed({{3{spd_ff[SPD_W-1]}}, spd_ff});
   logic signed [SPD_W+2:0] dcl;
   assign dcl  = (dlt > dvs) ? dvs : ((dlt < -dvs) ? -dvs : dlt);
   assign snew = $signed({{3{spd_ff[SPD_W-1]}}, spd_ff}) + dcl;

   logic [PRD_W-1:0] dvm, dpm;
   assign dvm = PRD_W'(acc_sel) * PRD_W'(tick_period);
   assign dpm = PRD_W'(aspd) * PRD_W'(tick_period);

   action_type act;
   assign act = action_type'(req_action);

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0; goal_ff <= '0; spd_ff <= '0; jspd_ff <= '0;
         lim_ff <= '0; acc_ff <= '0; mode_ff <= MODE_IDLE;
         en_ff <= 1'b0; arr_ff <= 1'b0;
      end else begin
         if (cmd.load) begin
            arr_ff <= 1'b0;
            en_ff  <= req_drive_enabled;
            case (act)
               ACT_MOVE: begin
                  goal_ff <= req_target_pos;
                  lim_ff  <= (req_peak_vel < HALF) ? HALF : req_peak_vel;
                  acc_ff  <= move_acc;
                  mode_ff <= MODE_MOVE;
               end
               ACT_JOG: begin
                  jspd_ff <= req_jog_vel;
                  mode_ff <= (req_jog_vel == '0) ? MODE_IDLE : MODE_JOG;
               end
               ACT_STOP: begin
                  goal_ff <= pos_ff;
                  if (lim_ff < HALF) lim_ff <= HALF;
                  acc_ff  <= default_accel;
                  mode_ff <= MODE_IDLE;
               end
               ACT_SYNC: begin
                  goal_ff <= req_actual_pos;
               end
               default: begin
               end
            endcase
            // sync or a disabled drive takes the measured position
            if (!req_drive_enabled || act == ACT_SYNC)
               pos_ff <= req_actual_pos;
            if (!req_drive_enabled || act == ACT_MOVE || act == ACT_STOP)
               spd_ff <= '0;
            // jog target is known now
            want_ff <= (SPD_W+2)'(req_action == ACT_JOG ? req_jog_vel : jspd_ff);
         end
         if (cmd.err) begin
            err_ff <= err_c;
            rad_ff <= RAD_W'({acc_ff, 1'b0}) * RAD_W'(aerr_c);
            if (aerr_c < EPS && aspd < SPD_W'(HALF)) begin
               pos_ff  <= goal_ff;
               spd_ff  <= '0;
               mode_ff <= MODE_IDLE;
               arr_ff  <= 1'b1;
            end
         end
         if (cmd.sqrt_go) begin
            root_ff <= '0;
            rem_ff  <= '0;
            it_ff   <= '0;
         end
         if (cmd.sqrt_step) begin
            rad_ff <= rad_ff << 2;
            it_ff  <= it_ff + 1'b1;
            if (rem_nx >= trial) begin
               rem_ff  <= RAD_W'(rem_nx - trial);
               root_ff <= {root_ff[ROOT_W-1:0], 1'b1};
            end else begin
               rem_ff  <= RAD_W'(rem_nx);
               root_ff <= {root_ff[ROOT_W-1:0], 1'b0};
            end
         end
         if (cmd.dv) begin
            dv_ff <= rnd(dvm);
            if (mode_ff == MODE_MOVE)
               want_ff <= err_ff[POS_W] ? -$signed({3'b000, vmag})
                                        : $signed({3'b000, vmag});
         end
         if (cmd.speed) begin
            if (snew > $signed((SPD_W+3)'((1 << (SPD_W-1)) - 1)))
               spd_ff <= {1'b0, {(SPD_W-1){1'b1}}};
            else if (snew < -$signed((SPD_W+3)'(1 << (SPD_W-1))))
               spd_ff <= {1'b1, {(SPD_W-1){1'b0}}};
            else
               spd_ff <= SPD_W'(snew);
         end
         if (cmd.dp) begin
            dp_ff <= spd_ff[SPD_W-1] ? -$signed(SPD_W'(rnd(dpm)))
                                     : $signed(SPD_W'(rnd(dpm)));
         end
         if (cmd.pos) begin
            np_ff <= $signed({{2{pos_ff[POS_W-1]}}, pos_ff})
                   + $signed({{6{dp_ff[SPD_W-1]}}, dp_ff});
         end
         if (cmd.clamp) begin
            logic signed [POS_W+1:0] p;
            p = np_ff;
            if (p > P_MAX)
               p = P_MAX;
            if (p < P_MIN)
               p = P_MIN;
            if (mode_ff == MODE_JOG) begin
               if (p < $signed({{2{soft_min[POS_W-1]}}, soft_min}))
                  p = {{2{soft_min[POS_W-1]}}, soft_min};
               if (p > $signed({{2{soft_max[POS_W-1]}}, soft_max}))
                  p = {{2{soft_max[POS_W-1]}}, soft_max};
            end
            pos_ff <= POS_W'(p);
         end
      end
   end

   assign status.enabled   = en_ff;
   assign status.mode      = mode_ff;
   assign status.arrive    = (aerr_c < EPS) && (aspd < SPD_W'(HALF));
   assign status.sqrt_done = (it_ff == ITER_W'(RAD_W/2 - 1)) && cmd.sqrt_step;

   assign rsp_setpoint = pos_ff;
   assign rsp_velocity = spd_ff;
   assign rsp_mode     = mode_ff;
   assign rsp_arrived  = arr_ff;

endmodule

[tb/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Trapezoidal motion generator testbench
// Drives control ticks with move, jog, stop and sync commands under several
// register settings, predicts every setpoint, velocity, mode and arrival flag
// in a Q16 model of the axis, and compares each result transfer in order.
// ----------------------------------------------------------------------------
module testbench;
   import tmg_pkg::*;

   localparam int  FRAC      = 16;
   localparam longint Q_HALF = longint'(1) << (FRAC - 1);
   localparam longint Q_EPS  = ((longint'(5) << FRAC) + 500) / 1000;
   localparam longint SPD_HI = (longint'(1) << 27) - 1;
   localparam longint SPD_LO = -(longint'(1) << 27);
   localparam longint POS_HI = 64'sd2147483647;
   localparam longint POS_LO = -64'sd2147483648;
   localparam int  PHASES    = 12;
   localparam int  PHASE_LEN = 60;
   localparam int  QUIET_AT  = 720;
   localparam int  CYCLE_CAP = 2000000;

   typedef struct {
      logic [2:0]        action;
      logic signed [31:0] target;
      logic [26:0]       peak;
      logic [27:0]       accel;
      logic signed [27:0] jog;
      logic signed [31:0] actual;
      logic              enabled;
   } tick_cmd_t;

   typedef struct {
      logic signed [31:0] setpoint;
      logic signed [27:0] velocity;
      logic [1:0]        mode;
      logic              arrived;
   } axis_out_t;

   // Axis model plus the queue of setpoints still owed by the block.
   class setpoint_scoreboard;
      longint unsigned default_accel = 6553600, jog_accel = 13107200, dt = 66;
      longint soft_min = POS_LO, soft_max = POS_HI;
      longint position = 0, speed = 0, goal = 0, jog_speed = 0;
      longint unsigned speed_limit = 0, accel_now = 0;
      mode_type run_mode = MODE_IDLE;
      axis_out_t owed[$];
      bit failed = 0;

      function void set_reg(logic [2:0] idx, logic [31:0] data);
         case (idx)
            CSR_DEFAULT_ACCEL: default_accel = data[27:0];
            CSR_JOG_ACCEL:     jog_accel = data[27:0];
            CSR_SOFT_MIN:      soft_min = longint'($signed(data));
            CSR_SOFT_MAX:      soft_max = longint'($signed(data));
            CSR_TICK_PERIOD:   dt = data[12:0];
            default: ;
         endcase
      endfunction

      // x*dt in Q16, rounded half away from zero
      function longint scale_dt(longint x);
         longint unsigned mag, r;
         mag = (x < 0) ? longint'(-x) : x;
         r = (mag * dt + (longint'(1) << (FRAC - 1))) >> FRAC;
         return (x < 0) ? -longint'(r) : longint'(r);
      endfunction

      function longint unsigned root(longint unsigned n);
         longint unsigned res, b;
         res = 0;
         b = longint'(1) << 62;
         while (b > n) b >>= 2;
         while (b != 0) begin
            if (n >= res + b) begin
               n -= res + b;
               res = (res >> 1) + b;
            end else begin
               res >>= 1;
            end
            b >>= 2;
         end
         return res;
      endfunction

      function longint clip(longint v, longint lo, longint hi);
         return (v < lo) ? lo : ((v > hi) ? hi : v);
      endfunction

      function void slew(longint want, longint unsigned acc);
         longint dv, s;
         dv = scale_dt(longint'(acc));
         s = clip(speed + clip(want - speed, -dv, dv), SPD_LO, SPD_HI);
         speed = s;
         position = clip(position + scale_dt(s), POS_LO, POS_HI);
      endfunction

      function void note_input(tick_cmd_t c);
         axis_out_t o;
         longint err, aerr, aspd, want;
         longint unsigned vmag;
         o.arrived = 0;
         case (c.action)
            ACT_MOVE: begin
               goal = c.target;
               speed_limit = (c.peak < Q_HALF) ? Q_HALF : c.peak;
               speed = 0;
               accel_now = (c.accel != 0) ? c.accel : default_accel;
               run_mode = MODE_MOVE;
            end
            ACT_JOG: begin
               jog_speed = c.jog;
               run_mode = (c.jog == 0) ? MODE_IDLE : MODE_JOG;
            end
            ACT_STOP: begin
               goal = position;
               if (speed_limit < Q_HALF) speed_limit = Q_HALF;
               speed = 0;
               accel_now = default_accel;
               run_mode = MODE_IDLE;
            end
            ACT_SYNC: begin
               position = c.actual;
               goal = c.actual;
            end
            default: ;
         endcase
         if (!c.enabled) begin
            position = c.actual;
            speed = 0;
         end else if (run_mode == MODE_MOVE) begin
            err = goal - position;
            aerr = (err < 0) ? -err : err;
            aspd = (speed < 0) ? -speed : speed;
            if (aerr < Q_EPS && aspd < Q_HALF) begin
               position = goal;
               speed = 0;
               run_mode = MODE_IDLE;
               o.arrived = 1;
            end else begin
               vmag = root(2 * accel_now * longint'(aerr));
               if (vmag > speed_limit) vmag = speed_limit;
               want = (err > 0) ? longint'(vmag) : -longint'(vmag);
               slew(want, accel_now);
            end
         end else if (run_mode == MODE_JOG) begin
            slew(jog_speed, jog_accel);
            if (position < soft_min) position = soft_min;
            if (position > soft_max) position = soft_max;
         end
         o.setpoint = position[31:0];
         o.velocity = speed[27:0];
         o.mode = run_mode;
         owed.insert(owed.size(), o);
      endfunction

      function void check_result(axis_out_t got);
         axis_out_t e;
         if (owed.size() == 0) begin
            $error("unexpected result transfer, setpoint %0d", got.setpoint);
            failed = 1;
            return;
         end
         e = owed.pop_front();
         if (got.setpoint !== e.setpoint) begin
            $error("setpoint: expected %0d, got %0d", e.setpoint, got.setpoint);
            failed = 1;
         end
         if (got.velocity !== e.velocity) begin
            $error("velocity: expected %0d, got %0d", e.velocity, got.velocity);
            failed = 1;
         end
         if (got.mode !== e.mode) begin
            $error("mode: expected %0d, got %0d", e.mode, got.mode);
            failed = 1;
         end
         if (got.arrived !== e.arrived) begin
            $error("arrived: expected %0d, got %0d", e.arrived, got.arrived);
            failed = 1;
         end
      endfunction
   endclass

   logic                    clock = 0;
   logic                    reset = 1;
   logic                    req_valid = 0;
   logic                    req_ready;
   logic [2:0]              req_action = ACT_TICK;
   logic signed [31:0]      req_target_pos = '0;
   logic [26:0]             req_peak_vel = '0;
   logic [27:0]             req_move_accel = '0;
   logic signed [27:0]      req_jog_vel = '0;
   logic signed [31:0]      req_actual_pos = '0;
   logic                    req_drive_enabled = 1;
   logic                    rsp_valid;
   logic                    rsp_ready = 0;
   logic signed [31:0]      rsp_setpoint;
   logic signed [27:0]      rsp_velocity;
   logic [1:0]              rsp_mode;
   logic                    rsp_arrived;
   logic                    csr_valid = 0;
   logic                    csr_ready;
   logic [2:0]              csr_index = CSR_DEFAULT_ACCEL;
   logic [31:0]             csr_data = '0;

   setpoint_scoreboard sb = new();
   bit quiet = 0;      // no idling on either side once set
   int sent = 0;
   int cycles = 0;
   int stall_left = 0;

   trapezoidal_motion_generator DUT (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   // Watchdog: a hung handshake ends the run here.
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_CAP) begin
         $display("FAILED: results differ");
         $finish;
      end
   end

   // Result side: stall in random bursts, then take every transfer.
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 0;
      end else if (quiet) begin
         rsp_ready <= 1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 0;
      end else if ($urandom_range(0, 9) == 0) begin
         stall_left = $urandom_range(1, 18) - 1;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= 1;
      end
   end

   always @(posedge clock) begin
      axis_out_t got;
      if (!reset && rsp_valid && rsp_ready) begin
         got.setpoint = rsp_setpoint;
         got.velocity = rsp_velocity;
         got.mode = rsp_mode;
         got.arrived = rsp_arrived;
         sb.check_result(got);
      end
   end

   // Present one tick, with an optional idle burst first; hold until transfer.
   task send_tick(input tick_cmd_t c);
      if (!quiet && $urandom_range(0, 7) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 18)) @(posedge clock);
      end
      req_valid <= 1;
      req_action <= c.action;
      req_target_pos <= c.target;
      req_peak_vel <= c.peak;
      req_move_accel <= c.accel;
      req_jog_vel <= c.jog;
      req_actual_pos <= c.actual;
      req_drive_enabled <= c.enabled;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sb.note_input(c);
      sent++;
      if (sent >= QUIET_AT) quiet = 1;
   endtask

   // Leave csr_valid high; the caller drops it after the last write.
   task write_reg(input logic [2:0] idx, input logic [31:0] data);
      csr_valid <= 1;
      csr_index <= idx;
      csr_data <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      sb.set_reg(idx, data);
   endtask

   // Drain every owed result, then wait with no request or write pending.
   task drain();
      req_valid <= 0;
      csr_valid <= 0;
      @(posedge clock);
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);
   endtask

   function tick_cmd_t mk(logic [2:0] a, longint tgt = 0, longint pk = 0, longint ac = 0,
                          longint jg = 0, longint act = 0, bit en = 1);
      tick_cmd_t c;
      c.action = a;
      c.target = tgt[31:0];
      c.peak = pk[26:0];
      c.accel = ac[27:0];
      c.jog = jg[27:0];
      c.actual = act[31:0];
      c.enabled = en;
      return c;
   endfunction

   function tick_cmd_t noise();
      tick_cmd_t c;
      c.action = 3'($urandom_range(0, 7));
      c.target = $urandom;
      c.peak = 27'($urandom);
      c.accel = 28'($urandom);
      c.jog = 28'($urandom);
      c.actual = $urandom;
      c.enabled = $urandom_range(0, 3) != 0;
      return c;
   endfunction

   function bit drive_on();
      return $urandom_range(0, 19) != 0;
   endfunction

   task apply_settings(int p);
      case (p % 6)
         0: begin
            write_reg(CSR_DEFAULT_ACCEL, 1);
            write_reg(CSR_JOG_ACCEL, 1);
            write_reg(CSR_SOFT_MIN, 32'h8000_0000);
            write_reg(CSR_SOFT_MAX, 32'h7FFF_FFFF);
            write_reg(CSR_TICK_PERIOD, 1);
         end
         1: begin
            write_reg(CSR_DEFAULT_ACCEL, 28'hFFF_FFFF);
            write_reg(CSR_JOG_ACCEL, 28'hFFF_FFFF);
            write_reg(CSR_SOFT_MIN, -(32'sd40 << FRAC));
            write_reg(CSR_SOFT_MAX, 32'sd40 << FRAC);
            write_reg(CSR_TICK_PERIOD, 6554);
         end
         5: begin
            // random limits may cross, dt may be zero
            write_reg(CSR_DEFAULT_ACCEL, $urandom_range(1, 28'hFFF_FFFF));
            write_reg(CSR_JOG_ACCEL, $urandom_range(1, 28'hFFF_FFFF));
            write_reg(CSR_SOFT_MIN, $urandom);
            write_reg(CSR_SOFT_MAX, $urandom);
            write_reg(CSR_TICK_PERIOD, $urandom_range(0, 6554));
         end
         default: begin
            write_reg(CSR_DEFAULT_ACCEL, $urandom_range(200, 3000) << FRAC);
            write_reg(CSR_JOG_ACCEL, $urandom_range(100, 2000) << FRAC);
            write_reg(CSR_SOFT_MIN, -($urandom_range(5, 200) << FRAC));
            write_reg(CSR_SOFT_MAX, $urandom_range(5, 200) << FRAC);
            write_reg(CSR_TICK_PERIOD, $urandom_range(66, 1311));
         end
      endcase
   endtask

   task run_phase();
      int n;
      longint tgt;
      n = 0;
      while (n < PHASE_LEN) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
               // move to a nearby target and tick until it lands, for at most 60 ticks
               tgt = sb.clip(sb.position + longint'($urandom_range(0, 1 << 20)) - (1 << 19),
                             POS_LO, POS_HI);
               send_tick(mk(ACT_MOVE, tgt, $urandom_range(0, 1 << 23),
                            ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 1 << 27),
                            0, $urandom, drive_on()));
               n++;
               for (int k = 0; k < 60 && sb.run_mode == MODE_MOVE; k++) begin
                  send_tick(mk(ACT_TICK, 0, 0, 0, 0, $urandom, drive_on()));
                  n++;
               end
            end
            6, 7: begin
               send_tick(mk(ACT_JOG, 0, 0, 0, $signed($urandom_range(0, 1 << 24)) - (1 << 23),
                            $urandom, 1));
               n++;
               repeat ($urandom_range(2, 12)) begin
                  send_tick(mk(ACT_TICK, 0, 0, 0, 0, $urandom, drive_on()));
                  n++;
               end
               send_tick(($urandom_range(0, 1) != 0) ? mk(ACT_STOP, 0, 0, 0, 0, 0, 1)
                                                     : mk(ACT_JOG, 0, 0, 0, 0, 0, 1));
               n++;
            end
            default: begin
               send_tick(noise());
               n++;
            end
         endcase
      end
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // Directed: floored peak and default accel, odd actions, saturation, disable.
      send_tick(mk(ACT_TICK));
      send_tick(mk(ACT_MOVE, 1000, 0, 0));
      send_tick(mk(ACT_TICK));
      send_tick(mk(ACT_TICK));
      send_tick(mk(3'd5));
      send_tick(mk(3'd6));
      send_tick(mk(3'd7));
      send_tick(mk(ACT_STOP));
      send_tick(mk(ACT_SYNC, 0, 0, 0, 0, 32'sh7FFF_FF00));
      send_tick(mk(ACT_JOG, 0, 0, 0, 134217727));
      send_tick(mk(ACT_TICK));
      send_tick(mk(ACT_TICK));
      send_tick(mk(ACT_JOG, 0, 0, 0, -134217728));
      send_tick(mk(ACT_TICK, 0, 0, 0, 0, POS_LO, 0));
      send_tick(mk(ACT_TICK, 0, 0, 0, 0, 32'sh7FFF_FFFF, 0));
      send_tick(mk(ACT_TICK));
      send_tick(mk(ACT_JOG, 0, 0, 0, 0));
      send_tick(mk(ACT_MOVE, POS_HI, 27'h7FF_FFFF, 28'hFFF_FFFF));
      send_tick(mk(ACT_TICK));
      send_tick(mk(ACT_MOVE, POS_LO, 27'h7FF_FFFF, 28'hFFF_FFFF));
      send_tick(mk(ACT_TICK));
      send_tick(mk(ACT_STOP));
      send_tick(mk(ACT_SYNC, 0, 0, 0, 0, 0));

      // Random phases, each behind a full drain so register writes see an idle block.
      for (int p = 0; p < PHASES; p++) begin
         drain();
         apply_settings(p);
         csr_valid <= 0;
         @(posedge clock);
         run_phase();
      end

      drain();
      repeat (100) @(posedge clock);
      if (!sb.failed && sb.owed.size() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule

[trapezoidal_motion_generator.f]
rtl/core/tmg_pkg.sv
rtl/core/tmg_ctrl.sv
rtl/core/tmg_datapath.sv
rtl/core/trapezoidal_motion_generator.sv
tb/testbench.sv
